/* src/sqfm_pkg.sv */
// package for the spi / quad-spi flash master
// command codes, pulse counts and line levels; no dependencies
package sqfm_pkg;

  typedef enum logic [2:0] {
    CMD_TX_SINGLE = 3'd0,
    CMD_RX_SINGLE = 3'd1,
    CMD_TX_QUAD   = 3'd2,
    CMD_RX_QUAD   = 3'd3,
    CMD_IDLE      = 3'd4,
    CMD_END       = 3'd5
  } cmd_t;

  localparam int CNT_W           = 7;
  localparam int MAX_IDLE_CLOCKS = 64;
  localparam int BYTE_W          = 8;
  localparam int LINE_W          = 4;

  localparam logic [CNT_W-1:0] SINGLE_PULSES = CNT_W'(8);
  localparam logic [CNT_W-1:0] QUAD_PULSES   = CNT_W'(2);
  localparam logic [CNT_W-1:0] END_PULSES    = CNT_W'(1);
  localparam logic [CNT_W-1:0] IDLE_MAX      = CNT_W'(MAX_IDLE_CLOCKS);

  localparam logic [LINE_W-1:0] LINE_ONE  = 4'hf;
  localparam logic [LINE_W-1:0] LINE_ZERO = 4'he;

endpackage

/* src/spi_qspi_flash_master.sv */
// spi / quad-spi flash master, mode 0 style clocking, one result per clock pulse
// depends on sqfm_pkg (command codes, pulse counts, line levels)
//
// usage: the input channel (in_valid / in_stall) takes one byte command per item:
// tx single, rx single, tx quad, rx quad, idle clocks or end of transaction.
// the result channel (out_valid / out_stall) gives one item per serial clock
// pulse, or one select release for an end command; out_last marks the final
// result of each command. single commands give 8 results, quad commands 2,
// idle gives min(idle_count, 64) results (none for zero), end gives 1; unused
// command codes are accepted and give nothing.
// the byte moves through one shift register one bit (single) or one nibble
// (quad) per pulse.
// the command is first registered in the sequencer and its first result then in
// the output register. in_stall stays high while a command is being expanded, so
// no new command is taken until the last result of the current one is emitted.
// when the receiver stalls, the output register holds its result and the
// sequencer waits; nothing is dropped or repeated.
// reset (rst_n low, synchronous) releases the internal select, turns the data
// drive state off, sets the line level to 4'h0 and empties the output register.
module spi_qspi_flash_master (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [2:0]                     in_command,
  input  logic [sqfm_pkg::BYTE_W-1:0]    in_tx_byte,
  input  logic [sqfm_pkg::CNT_W-1:0]     in_idle_count,
  input  logic [sqfm_pkg::BYTE_W-1:0]    in_line_samples,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_clock_pulse,
  output logic [sqfm_pkg::LINE_W-1:0]    out_data_out,
  output logic                           out_data_drive,
  output logic                           out_select_n,
  output logic [sqfm_pkg::BYTE_W-1:0]    out_rx_byte,
  output logic                           out_rx_valid,
  output logic                           out_last
);

  logic                          busy_r, busy_nxt;
  logic [2:0]                    cmd_r, cmd_nxt;
  logic [sqfm_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [sqfm_pkg::BYTE_W-1:0]   data_r, data_nxt;
  logic                          sel_r, sel_nxt;
  logic                          drv_r, drv_nxt;
  logic [sqfm_pkg::LINE_W-1:0]   line_r, line_nxt;

  logic                          ov_r, ov_nxt;
  logic                          o_pulse_r, o_pulse_nxt;
  logic [sqfm_pkg::LINE_W-1:0]   o_data_r, o_data_nxt;
  logic                          o_drive_r, o_drive_nxt;
  logic                          o_seln_r, o_seln_nxt;
  logic [sqfm_pkg::BYTE_W-1:0]   o_rx_r, o_rx_nxt;
  logic                          o_rxv_r, o_rxv_nxt;
  logic                          o_last_r, o_last_nxt;

  logic                          accept;
  logic                          emit;
  logic                          is_last;
  logic [sqfm_pkg::CNT_W-1:0]    load_cnt;
  logic [sqfm_pkg::BYTE_W-1:0]   data_rot;

  assign accept  = in_valid && !in_stall;
  assign emit    = busy_r && (!ov_r || !out_stall);
  assign is_last = (cnt_r == sqfm_pkg::END_PULSES);

  always_comb begin
    case (in_command)
      sqfm_pkg::CMD_TX_SINGLE, sqfm_pkg::CMD_RX_SINGLE: load_cnt = sqfm_pkg::SINGLE_PULSES;
      sqfm_pkg::CMD_TX_QUAD, sqfm_pkg::CMD_RX_QUAD:     load_cnt = sqfm_pkg::QUAD_PULSES;
      sqfm_pkg::CMD_IDLE: begin
        load_cnt = (in_idle_count > sqfm_pkg::IDLE_MAX) ? sqfm_pkg::IDLE_MAX : in_idle_count;
      end
      sqfm_pkg::CMD_END:                                load_cnt = sqfm_pkg::END_PULSES;
      default:                                          load_cnt = '0;
    endcase
  end

  // rotate one bit for single commands, one nibble for quad
  always_comb begin
    if (cmd_r == sqfm_pkg::CMD_TX_QUAD || cmd_r == sqfm_pkg::CMD_RX_QUAD) begin
      data_rot = {data_r[3:0], data_r[7:4]};
    end else begin
      data_rot = {data_r[6:0], data_r[7]};
    end
  end

  always_comb begin
    busy_nxt    = busy_r;
    cmd_nxt     = cmd_r;
    cnt_nxt     = cnt_r;
    data_nxt    = data_r;
    sel_nxt     = sel_r;
    drv_nxt     = drv_r;
    line_nxt    = line_r;
    ov_nxt      = ov_r;
    o_pulse_nxt = o_pulse_r;
    o_data_nxt  = o_data_r;
    o_drive_nxt = o_drive_r;
    o_seln_nxt  = o_seln_r;
    o_rx_nxt    = o_rx_r;
    o_rxv_nxt   = o_rxv_r;
    o_last_nxt  = o_last_r;

    if (ov_r && !out_stall) begin
      ov_nxt = 1'b0;
    end

    if (accept) begin
      cmd_nxt  = in_command;
      cnt_nxt  = load_cnt;
      busy_nxt = (load_cnt != '0);
      case (in_command)
        sqfm_pkg::CMD_TX_SINGLE, sqfm_pkg::CMD_TX_QUAD: begin
          data_nxt = in_tx_byte;
          sel_nxt  = 1'b1;
          drv_nxt  = 1'b1;
        end
        sqfm_pkg::CMD_RX_SINGLE, sqfm_pkg::CMD_RX_QUAD: begin
          data_nxt = in_line_samples;
          sel_nxt  = 1'b1;
          drv_nxt  = 1'b0;
        end
        sqfm_pkg::CMD_END: begin
          sel_nxt = 1'b0;
        end
        default: begin
        end
      endcase
    end

    if (emit) begin
      ov_nxt      = 1'b1;
      o_pulse_nxt = (cmd_r != sqfm_pkg::CMD_END);
      o_drive_nxt = drv_r;
      o_seln_nxt  = !sel_r;
      o_last_nxt  = is_last;
      o_rx_nxt    = '0;
      o_rxv_nxt   = 1'b0;
      o_data_nxt  = line_r;
      data_nxt    = data_rot;
      cnt_nxt     = cnt_r - sqfm_pkg::END_PULSES;
      busy_nxt    = !is_last;
      case (cmd_r)
        sqfm_pkg::CMD_TX_SINGLE: begin
          line_nxt   = data_r[7] ? sqfm_pkg::LINE_ONE : sqfm_pkg::LINE_ZERO;
          o_data_nxt = line_nxt;
        end
        sqfm_pkg::CMD_TX_QUAD: begin
          line_nxt   = data_r[7:4];
          o_data_nxt = line_nxt;
        end
        sqfm_pkg::CMD_RX_SINGLE, sqfm_pkg::CMD_RX_QUAD: begin
          if (is_last) begin
            o_rx_nxt  = data_rot;
            o_rxv_nxt = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cmd_r  <= '0;
      cnt_r  <= '0;
      sel_r  <= 1'b0;
      drv_r  <= 1'b0;
      line_r <= '0;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      cmd_r  <= cmd_nxt;
      cnt_r  <= cnt_nxt;
      sel_r  <= sel_nxt;
      drv_r  <= drv_nxt;
      line_r <= line_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r    <= data_nxt;
    o_pulse_r <= o_pulse_nxt;
    o_data_r  <= o_data_nxt;
    o_drive_r <= o_drive_nxt;
    o_seln_r  <= o_seln_nxt;
    o_rx_r    <= o_rx_nxt;
    o_rxv_r   <= o_rxv_nxt;
    o_last_r  <= o_last_nxt;
  end

  assign in_stall        = busy_r;
  assign out_valid       = ov_r;
  assign out_clock_pulse = o_pulse_r;
  assign out_data_out    = o_data_r;
  assign out_data_drive  = o_drive_r;
  assign out_select_n    = o_seln_r;
  assign out_rx_byte     = o_rx_r;
  assign out_rx_valid    = o_rxv_r;
  assign out_last        = o_last_r;

`ifndef NO_ASSERTIONS
  a_busy_has_count: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (cnt_r != '0))
    else $error("busy with no pulses left");

  a_last_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && is_last) |=> (!busy_r && ov_r && o_last_r))
    else $error("final pulse did not close the command");

  a_rx_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> (!o_rxv_r || o_last_r))
    else $error("received byte reported before the final pulse");

  a_release_deselects: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !o_pulse_r) |-> (o_seln_r && o_last_r))
    else $error("select release without select high");
`endif

endmodule
